// ----- hdl/tem_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tem_pkg: shared types and constants for the text extent measure block
// Field widths, command and register codes, and the lookup result bundle.
// ---------------------------------------------------------------------------
package tem_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_ACC_WIDTH   = 24;

    localparam int CODE_W     = 16;
    localparam int ADV_W      = 16;
    localparam int INDEX_W    = 8;
    localparam int COUNT_W    = 9;
    localparam int HEIGHT_W   = 16;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_CHAR = 1'b1;

    localparam logic [CODE_W-1:0] NEWLINE_CODE = 16'd10;
    localparam logic [CODE_W-1:0] END_CODE     = 16'd0;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MISSING_INDEX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FONT_HEIGHT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_SPACING  = 2'd3;

    // Lookup completion: pulse plus the advance that was selected
    typedef struct packed {
        logic             done;
        logic [ADV_W-1:0] adv;
    } lookup_res_t;

endpackage
`default_nettype wire

// ----- hdl/tem_glyph_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tem_glyph_ram: glyph code and advance store
// One write port and one registered read port; both fields share an address.
// ---------------------------------------------------------------------------
module tem_glyph_ram #(
    parameter int DEPTH = tem_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW    = $clog2(tem_pkg::DEFAULT_TABLE_DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [AW-1:0]             wr_addr,
    input  wire logic [tem_pkg::CODE_W-1:0] wr_code,
    input  wire logic [tem_pkg::ADV_W-1:0]  wr_adv,
    input  wire logic                      rd_en,
    input  wire logic [AW-1:0]             rd_addr,
    output logic      [tem_pkg::CODE_W-1:0] rd_code,
    output logic      [tem_pkg::ADV_W-1:0]  rd_adv
);

    logic [tem_pkg::CODE_W-1:0] code_store_reg [DEPTH];
    logic [tem_pkg::ADV_W-1:0]  adv_store_reg  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_store_reg[wr_addr] <= wr_code;
            adv_store_reg[wr_addr]  <= wr_adv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_code <= code_store_reg[rd_addr];
            rd_adv  <= adv_store_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ----- hdl/tem_lookup.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tem_lookup: binary search sequencer over the glyph store
// Probes the low end, the high end, then halves the range, one read a cycle,
// with a single compare unit; falls back to the missing-glyph advance.
// ---------------------------------------------------------------------------
module tem_lookup #(
    parameter int TABLE_DEPTH = tem_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = $clog2(tem_pkg::DEFAULT_TABLE_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tem_pkg::CODE_W-1:0]  key,
    input  wire logic [tem_pkg::COUNT_W-1:0] glyph_count,
    input  wire logic [tem_pkg::INDEX_W-1:0] missing_index,
    output logic                             busy,
    output tem_pkg::lookup_res_t             res,
    output logic                             rd_en,
    output logic      [AW-1:0]               rd_addr,
    input  wire logic [tem_pkg::CODE_W-1:0]  rd_code,
    input  wire logic [tem_pkg::ADV_W-1:0]   rd_adv
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LO    = 3'd1;
    localparam logic [2:0] ST_HI    = 3'd2;
    localparam logic [2:0] ST_MID   = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_MISS  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [tem_pkg::CODE_W-1:0] key_reg, key_next;
    logic [AW-1:0]              lo_reg, lo_next;
    logic [AW-1:0]              hi_reg, hi_next;
    logic                       lo_below_reg, lo_below_next;

    logic [31:0]   count_clip;
    logic [AW-1:0] hi_start;
    logic          count_zero;
    logic          miss_ok;
    logic [AW-1:0] miss_addr;
    logic [AW-1:0] mid;
    logic [AW-1:0] nlo, nhi, nmid, nspan;
    logic          eq, lt;

    assign count_clip = (32'(glyph_count) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                               : 32'(glyph_count);
    assign hi_start   = AW'(count_clip - 32'd1);
    assign count_zero = (glyph_count == '0);
    assign miss_ok    = (32'(missing_index) < 32'(TABLE_DEPTH));
    assign miss_addr  = AW'(missing_index);

    // Shared compare unit
    assign eq = (rd_code == key_reg);
    assign lt = (rd_code < key_reg);

    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign nlo   = lt ? mid : lo_reg;
    assign nhi   = lt ? hi_reg : mid;
    assign nspan = nhi - nlo;
    assign nmid  = nlo + (nspan >> 1);

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        lo_below_next = lo_below_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        res.done      = 1'b0;
        res.adv       = rd_adv;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    key_next = key;
                    lo_next  = '0;
                    hi_next  = hi_start;
                    rd_en    = 1'b1;
                    if (count_zero)
                    begin
                        rd_addr    = miss_addr;
                        state_next = ST_MISS;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        state_next = ST_LO;
                    end
                end
            end
            ST_LO:
            begin
                if (eq)
                begin
                    res.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    lo_below_next = lt;
                    rd_en         = 1'b1;
                    rd_addr       = hi_reg;
                    state_next    = ST_HI;
                end
            end
            ST_HI:
            begin
                if (eq)
                begin
                    res.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid;
                    if ((hi_reg > AW'(1)) && lo_below_reg && !lt)
                        state_next = ST_MID;
                    else
                        state_next = ST_FINAL;
                end
            end
            ST_MID:
            begin
                if (eq)
                begin
                    res.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Both ends stay strictly around the key; only the span decides
                    lo_next = nlo;
                    hi_next = nhi;
                    rd_en   = 1'b1;
                    rd_addr = nmid;
                    if (nspan > AW'(1))
                        state_next = ST_MID;
                    else
                        state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                if (eq)
                begin
                    res.done   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = miss_addr;
                    state_next = ST_MISS;
                end
            end
            ST_MISS:
            begin
                res.done   = 1'b1;
                res.adv    = miss_ok ? rd_adv : '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lo_below_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lo_below_reg <= lo_below_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
    end

`ifndef SYNTHESIS
    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == ST_IDLE))
        else $error("lookup started while busy");

    a_mid_span_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MID) |-> (lo_reg < hi_reg))
        else $error("search range collapsed inside halving loop");

    a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res.done |=> (state_reg == ST_IDLE))
        else $error("lookup kept running after completion");
`endif

endmodule
`default_nettype wire

// ----- hdl/text_extent_measure.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// text_extent_measure: line and text extent from a sorted glyph table
// Looks up each character's advance by binary search and sums line widths.
// ---------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall): cmd 0 writes glyph entry
//   entry_index with char_code and advance; cmd 1 is a text character.
//   Code 10 closes a line, code 0 closes the text.
//   Result channel (result_valid / result_stall): one transaction per line
//   or text end, carrying line_width, max_width, text_height and is_final.
//   Config channel (cfg_valid / cfg_ready, always ready): cfg_index selects
//   glyph_count, missing_index, font_height or line_spacing.
// Timing:
//   A load is written to the glyph store as it is accepted. A character is looked
//   up with one glyph-store read per cycle (low end, high end, each halving
//   step, a final probe, and the missing-glyph read), all through one read
//   port and one compare unit. A newline or end first updates the height
//   sum, then loads the result register.
// Reset clears accumulators and registers to defaults (glyph_count = 1);
// the glyph store is not cleared. While a result is held by result_stall,
// loads and characters keep flowing; another newline or end waits.
// ---------------------------------------------------------------------------
module text_extent_measure #(
    parameter int TABLE_DEPTH = tem_pkg::DEFAULT_TABLE_DEPTH,
    parameter int ACC_WIDTH   = tem_pkg::DEFAULT_ACC_WIDTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           item_valid,
    output logic                                item_stall,
    input  wire logic                           cmd,
    input  wire logic [tem_pkg::INDEX_W-1:0]    entry_index,
    input  wire logic [tem_pkg::CODE_W-1:0]     char_code,
    input  wire logic [tem_pkg::ADV_W-1:0]      advance,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output logic      [tem_pkg::OUT_W-1:0]      line_width,
    output logic      [tem_pkg::OUT_W-1:0]      max_width,
    output logic      [tem_pkg::OUT_W-1:0]      text_height,
    output logic                                is_final,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [tem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [tem_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Configuration registers
    logic [tem_pkg::COUNT_W-1:0]  glyph_count_reg;
    logic [tem_pkg::INDEX_W-1:0]  missing_index_reg;
    logic [tem_pkg::HEIGHT_W-1:0] font_height_reg;
    logic [tem_pkg::HEIGHT_W-1:0] line_spacing_reg;

    // Running sums
    logic [ACC_WIDTH-1:0] line_accum_reg, line_accum_next;
    logic [ACC_WIDTH-1:0] max_accum_reg, max_accum_next;
    logic [ACC_WIDTH-1:0] height_accum_reg, height_accum_next;

    // Result staging
    logic                        pending_reg, pending_next;
    logic                        result_valid_reg, result_valid_next;
    logic [tem_pkg::OUT_W-1:0]   out_line_reg, out_line_next;
    logic [tem_pkg::OUT_W-1:0]   out_max_reg, out_max_next;
    logic [tem_pkg::OUT_W-1:0]   out_height_reg, out_height_next;
    logic                        out_final_reg, out_final_next;

    logic is_newline, is_end, is_result_item, is_search, is_load;
    logic accept;
    logic lookup_busy;
    tem_pkg::lookup_res_t lookup_res;

    logic                       ram_wr_en;
    logic                       ram_rd_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [tem_pkg::CODE_W-1:0] ram_rd_code;
    logic [tem_pkg::ADV_W-1:0]  ram_rd_adv;

    logic [ACC_WIDTH:0]   line_sum;
    logic [ACC_WIDTH:0]   height_step_sum;
    logic [ACC_WIDTH:0]   report_sum;
    logic [ACC_WIDTH-1:0] line_sat, height_step_sat, report_sat;

    // Decode the item
    assign is_newline     = (cmd == tem_pkg::CMD_CHAR) && (char_code == tem_pkg::NEWLINE_CODE);
    assign is_end         = (cmd == tem_pkg::CMD_CHAR) && (char_code == tem_pkg::END_CODE);
    assign is_result_item = is_newline || is_end;
    assign is_search      = (cmd == tem_pkg::CMD_CHAR) && !is_result_item;
    assign is_load        = (cmd == tem_pkg::CMD_LOAD);

    // Hold items while searching or finishing a report; a line or text end
    // also waits until the result register is free or draining.
    assign item_stall = lookup_busy || pending_reg ||
                        (is_result_item && result_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    assign cfg_ready = 1'b1;

    // Drop loads that fall outside the store
    assign ram_wr_en = accept && is_load && (32'(entry_index) < 32'(TABLE_DEPTH));

    tem_glyph_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (AW'(entry_index)),
        .wr_code (char_code),
        .wr_adv  (advance),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_code (ram_rd_code),
        .rd_adv  (ram_rd_adv)
    );

    tem_lookup #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_lookup (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept && is_search),
        .key           (char_code),
        .glyph_count   (glyph_count_reg),
        .missing_index (missing_index_reg),
        .busy          (lookup_busy),
        .res           (lookup_res),
        .rd_en         (ram_rd_en),
        .rd_addr       (ram_rd_addr),
        .rd_code       (ram_rd_code),
        .rd_adv        (ram_rd_adv)
    );

    // Saturating sums, one carry bit of headroom each
    assign line_sum        = {1'b0, line_accum_reg} + (ACC_WIDTH+1)'(lookup_res.adv);
    assign height_step_sum = {1'b0, height_accum_reg} + (ACC_WIDTH+1)'(font_height_reg)
                             + (ACC_WIDTH+1)'(line_spacing_reg);
    assign report_sum      = {1'b0, height_accum_reg} + (ACC_WIDTH+1)'(font_height_reg);

    assign line_sat        = line_sum[ACC_WIDTH] ? '1 : line_sum[ACC_WIDTH-1:0];
    assign height_step_sat = height_step_sum[ACC_WIDTH] ? '1 : height_step_sum[ACC_WIDTH-1:0];
    assign report_sat      = report_sum[ACC_WIDTH] ? '1 : report_sum[ACC_WIDTH-1:0];

    always_comb
    begin
        line_accum_next   = line_accum_reg;
        max_accum_next    = max_accum_reg;
        height_accum_next = height_accum_reg;
        pending_next      = pending_reg;
        result_valid_next = result_valid_reg;
        out_line_next     = out_line_reg;
        out_max_next      = out_max_reg;
        out_height_next   = out_height_reg;
        out_final_next    = out_final_reg;

        // Advance the line with the looked-up glyph
        if (lookup_res.done)
            line_accum_next = line_sat;

        // Drain the result register
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        // First step of a report: close the line, bump the height on a newline
        if (accept && is_result_item)
        begin
            if (line_accum_reg > max_accum_reg)
                max_accum_next = line_accum_reg;
            if (is_newline)
                height_accum_next = height_step_sat;
            line_accum_next = '0;
            out_line_next   = tem_pkg::OUT_W'(line_accum_reg);
            out_final_next  = is_end;
            pending_next    = 1'b1;
        end

        // Second step: load the report, clear the text state at the end
        if (pending_reg)
        begin
            out_max_next      = tem_pkg::OUT_W'(max_accum_reg);
            out_height_next   = tem_pkg::OUT_W'(report_sat);
            result_valid_next = 1'b1;
            pending_next      = 1'b0;
            if (out_final_reg)
            begin
                max_accum_next    = '0;
                height_accum_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_count_reg   <= tem_pkg::COUNT_W'(1);
            missing_index_reg <= '0;
            font_height_reg   <= '0;
            line_spacing_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                tem_pkg::REG_GLYPH_COUNT:
                    glyph_count_reg <= cfg_data[tem_pkg::COUNT_W-1:0];
                tem_pkg::REG_MISSING_INDEX:
                    missing_index_reg <= cfg_data[tem_pkg::INDEX_W-1:0];
                tem_pkg::REG_FONT_HEIGHT:
                    font_height_reg <= cfg_data[tem_pkg::HEIGHT_W-1:0];
                tem_pkg::REG_LINE_SPACING:
                    line_spacing_reg <= cfg_data[tem_pkg::HEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_accum_reg   <= '0;
            max_accum_reg    <= '0;
            height_accum_reg <= '0;
            pending_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            out_final_reg    <= 1'b0;
        end
        else
        begin
            line_accum_reg   <= line_accum_next;
            max_accum_reg    <= max_accum_next;
            height_accum_reg <= height_accum_next;
            pending_reg      <= pending_next;
            result_valid_reg <= result_valid_next;
            out_final_reg    <= out_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_line_reg   <= out_line_next;
        out_max_reg    <= out_max_next;
        out_height_reg <= out_height_next;
    end

    assign result_valid = result_valid_reg;
    assign line_width   = out_line_reg;
    assign max_width    = out_max_reg;
    assign text_height  = out_height_reg;
    assign is_final     = out_final_reg;

`ifndef SYNTHESIS
    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_result_item) |=> pending_reg)
        else $error("line or text end did not start a report");

    a_pending_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> !result_valid_reg)
        else $error("report step found result register occupied");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        lookup_res.done |-> !pending_reg)
        else $error("glyph lookup overlapped a report");
`endif

endmodule
`default_nettype wire

// ----- bench/tb_text_extent_measure.sv -----
// ---------------------------------------------------------------------------
// tb_text_extent_measure: self-checking bench for the text extent measure block
// A directed table, a full sorted glyph load, then random text phases under
// several register settings. A local model of the lookup and the saturating
// sums predicts each line and text result, which is checked field by field.
// ---------------------------------------------------------------------------
module tb_text_extent_measure;

    localparam int GLYPH_SLOTS    = tem_pkg::DEFAULT_TABLE_DEPTH;
    localparam int RESET_CYCLES   = 5;
    // Margin for any character lookup still in flight after the last result
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint unsigned ACC_LIMIT = (64'd1 << tem_pkg::DEFAULT_ACC_WIDTH) - 1;

    // One input transaction
    typedef struct packed {
        logic                        op;
        logic [tem_pkg::INDEX_W-1:0] slot;
        logic [tem_pkg::CODE_W-1:0]  code;
        logic [tem_pkg::ADV_W-1:0]   adv;
    } glyph_item_t;

    // One result transaction
    typedef struct packed {
        logic [tem_pkg::OUT_W-1:0] lw;
        logic [tem_pkg::OUT_W-1:0] mw;
        logic [tem_pkg::OUT_W-1:0] th;
        logic                      fin;
    } extent_t;

    // Directed row: the item plus an optional hand-written expectation
    typedef struct packed {
        glyph_item_t item;
        logic        typed;
        extent_t     want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           item_valid  = 1'b0;
    logic                           item_stall;
    logic                           cmd         = tem_pkg::CMD_LOAD;
    logic [tem_pkg::INDEX_W-1:0]    entry_index = '0;
    logic [tem_pkg::CODE_W-1:0]     char_code   = '0;
    logic [tem_pkg::ADV_W-1:0]      advance     = '0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    logic [tem_pkg::OUT_W-1:0]      line_width;
    logic [tem_pkg::OUT_W-1:0]      max_width;
    logic [tem_pkg::OUT_W-1:0]      text_height;
    logic                           is_final;
    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [tem_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [tem_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    // Local copy of the block's registers, at their reset values
    logic [tem_pkg::COUNT_W-1:0]  cfg_glyph_count = 9'd1;
    logic [tem_pkg::INDEX_W-1:0]  cfg_missing     = '0;
    logic [tem_pkg::HEIGHT_W-1:0] cfg_font_h      = '0;
    logic [tem_pkg::HEIGHT_W-1:0] cfg_spacing     = '0;

    // Local copy of the glyph store and the running sums
    logic [tem_pkg::CODE_W-1:0] code_tbl [0:GLYPH_SLOTS-1];
    logic [tem_pkg::ADV_W-1:0]  adv_tbl  [0:GLYPH_SLOTS-1];
    longint unsigned   line_acc   = 0;
    longint unsigned   max_acc    = 0;
    longint unsigned   height_acc = 0;

    extent_t   pending_extents [$];
    stim_row_t directed_rows   [$];
    extent_t   observed_extent;
    extent_t   due_extent;

    int mismatch_count = 0;
    int stuck_cycles   = 0;
    int send_idle_pct  = 16;
    int recv_idle_pct  = 60;

    text_extent_measure u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .cmd          (cmd),
        .entry_index  (entry_index),
        .char_code    (char_code),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .line_width   (line_width),
        .max_width    (max_width),
        .text_height  (text_height),
        .is_final     (is_final),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    function automatic longint unsigned clamp_sum(input longint unsigned a,
                                                  input longint unsigned b);
        return (a + b > ACC_LIMIT) ? ACC_LIMIT : a + b;
    endfunction

    // Binary search as the block does it: both ends first, then halve the
    // range while the key still lies strictly between the ends.
    function automatic bit find_glyph(input logic [tem_pkg::CODE_W-1:0] key,
                                      output int pos);
        int n;
        int lo;
        int hi;
        int mid;
        pos = 0;
        n = (cfg_glyph_count > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(cfg_glyph_count);
        if (n == 0)
            return 1'b0;
        lo  = 0;
        hi  = n - 1;
        mid = hi / 2;
        if (code_tbl[lo] == key)
        begin
            pos = lo;
            return 1'b1;
        end
        if (code_tbl[hi] == key)
        begin
            pos = hi;
            return 1'b1;
        end
        while ((hi - lo) > 1 && code_tbl[lo] < key && code_tbl[hi] > key)
        begin
            if (code_tbl[mid] == key)
            begin
                pos = mid;
                return 1'b1;
            end
            if (code_tbl[mid] < key)
                lo = mid;
            else
                hi = mid;
            mid = lo + (hi - lo) / 2;
        end
        if (code_tbl[mid] == key)
        begin
            pos = mid;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the local model by one accepted item; return 1 with the
    // expected extent when the item closes a line or the text.
    function automatic bit measure_step(input glyph_item_t it, output extent_t r);
        int              pos;
        longint unsigned step_adv;
        longint unsigned full_h;
        r = '0;
        if (it.op == tem_pkg::CMD_LOAD)
        begin
            code_tbl[it.slot] = it.code;
            adv_tbl[it.slot]  = it.adv;
            return 1'b0;
        end
        if (it.code == tem_pkg::NEWLINE_CODE || it.code == tem_pkg::END_CODE)
        begin
            if (it.code == tem_pkg::NEWLINE_CODE)
                height_acc = clamp_sum(height_acc,
                                       longint'(cfg_font_h) + longint'(cfg_spacing));
            if (line_acc > max_acc)
                max_acc = line_acc;
            full_h = clamp_sum(height_acc, longint'(cfg_font_h));
            r.lw   = line_acc[tem_pkg::OUT_W-1:0];
            r.mw   = max_acc[tem_pkg::OUT_W-1:0];
            r.th   = full_h[tem_pkg::OUT_W-1:0];
            r.fin  = (it.code == tem_pkg::END_CODE);
            line_acc = 0;
            if (it.code == tem_pkg::END_CODE)
            begin
                max_acc    = 0;
                height_acc = 0;
            end
            return 1'b1;
        end
        if (find_glyph(it.code, pos))
            step_adv = adv_tbl[pos];
        else
            step_adv = adv_tbl[cfg_missing];
        line_acc = clamp_sum(line_acc, step_adv);
        return 1'b0;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    function automatic stim_row_t glyph_row(input logic op,
                                            input logic [tem_pkg::INDEX_W-1:0] slot,
                                            input logic [tem_pkg::CODE_W-1:0] code,
                                            input logic [tem_pkg::ADV_W-1:0] adv,
                                            input logic typed,
                                            input logic [tem_pkg::OUT_W-1:0] lw,
                                            input logic [tem_pkg::OUT_W-1:0] mw,
                                            input logic [tem_pkg::OUT_W-1:0] th,
                                            input logic fin);
        stim_row_t r;
        r.item.op   = op;
        r.item.slot = slot;
        r.item.code = code;
        r.item.adv  = adv;
        r.typed     = typed;
        r.want.lw   = lw;
        r.want.mw   = mw;
        r.want.th   = th;
        r.want.fin  = fin;
        return r;
    endfunction

    // Mostly text: found codes, absent codes, line and text ends, and a few
    // table rewrites, half of which keep the order and half of which may not.
    function automatic glyph_item_t random_glyph_item();
        glyph_item_t it;
        int          roll;
        int          span;
        int          lo_b;
        int          hi_b;
        roll    = $urandom_range(99);
        it.op   = tem_pkg::CMD_CHAR;
        it.slot = tem_pkg::INDEX_W'($urandom);
        it.code = tem_pkg::CODE_W'($urandom);
        it.adv  = tem_pkg::ADV_W'($urandom);
        span = (cfg_glyph_count == 0 || cfg_glyph_count > GLYPH_SLOTS)
             ? GLYPH_SLOTS : int'(cfg_glyph_count);
        if (roll < 8)
        begin
            it.op = tem_pkg::CMD_LOAD;
            if ($urandom_range(1) == 1)
            begin
                lo_b = (it.slot == 0) ? 0 : int'(code_tbl[it.slot - 1]) + 1;
                hi_b = (it.slot == GLYPH_SLOTS - 1) ? 65535
                     : int'(code_tbl[it.slot + 1]) - 1;
                if (lo_b <= hi_b)
                    it.code = tem_pkg::CODE_W'($urandom_range(hi_b, lo_b));
            end
        end
        else if (roll < 20)
            it.code = tem_pkg::NEWLINE_CODE;
        else if (roll < 25)
            it.code = tem_pkg::END_CODE;
        else if (roll < 70)
            it.code = code_tbl[$urandom_range(span - 1)];
        else if (roll < 80)
            it.code = code_tbl[$urandom_range(span - 1)] + 1'b1;
        return it;
    endfunction

    // Present one transaction, hold it through stall, then predict
    task automatic send_item(input glyph_item_t it, input bit typed, input extent_t want);
        extent_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        item_valid  <= 1'b1;
        cmd         <= it.op;
        entry_index <= it.slot;
        char_code   <= it.code;
        advance     <= it.adv;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (measure_step(it, predicted))
            pending_extents.push_back(typed ? want : predicted);
    endtask

    // Drop valid, wait for every outstanding result, then let any lookup
    // still in flight finish
    task automatic wait_block_idle();
        item_valid <= 1'b0;
        while (pending_extents.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_setting(input logic [tem_pkg::CFG_IDX_W-1:0] reg_sel,
                                 input logic [tem_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (reg_sel)
            tem_pkg::REG_GLYPH_COUNT:   cfg_glyph_count = value[tem_pkg::COUNT_W-1:0];
            tem_pkg::REG_MISSING_INDEX: cfg_missing     = value[tem_pkg::INDEX_W-1:0];
            tem_pkg::REG_FONT_HEIGHT:   cfg_font_h      = value[tem_pkg::HEIGHT_W-1:0];
            tem_pkg::REG_LINE_SPACING:  cfg_spacing     = value[tem_pkg::HEIGHT_W-1:0];
            default:                    ;
        endcase
    endtask

    // One phase: idle the block, load all four registers, send text, and
    // always close the text so the phase ends on a final result.
    // The saturating phase maxes the missing advance with no glyph found,
    // runs one very long line, then enough newlines to clip the height.
    task automatic run_phase(input logic [tem_pkg::CFG_DATA_W-1:0] glyphs,
                             input logic [tem_pkg::CFG_DATA_W-1:0] miss,
                             input logic [tem_pkg::CFG_DATA_W-1:0] font_h,
                             input logic [tem_pkg::CFG_DATA_W-1:0] spacing,
                             input int n_items, input bit saturate);
        glyph_item_t it;
        wait_block_idle();
        write_setting(tem_pkg::REG_GLYPH_COUNT, glyphs);
        write_setting(tem_pkg::REG_MISSING_INDEX, miss);
        write_setting(tem_pkg::REG_FONT_HEIGHT, font_h);
        write_setting(tem_pkg::REG_LINE_SPACING, spacing);
        cfg_valid <= 1'b0;
        if (saturate)
        begin
            it.op   = tem_pkg::CMD_LOAD;
            it.slot = cfg_missing;
            it.code = code_tbl[cfg_missing];
            it.adv  = '1;
            send_item(it, 1'b0, '0);
            it.op = tem_pkg::CMD_CHAR;
            repeat (257)
            begin
                it.slot = tem_pkg::INDEX_W'($urandom);
                it.code = tem_pkg::CODE_W'($urandom_range(65535, 11));
                it.adv  = tem_pkg::ADV_W'($urandom);
                send_item(it, 1'b0, '0);
            end
            it.code = tem_pkg::NEWLINE_CODE;
            repeat (129) send_item(it, 1'b0, '0);
        end
        else
        begin
            repeat (n_items) send_item(random_glyph_item(), 1'b0, '0);
        end
        it.op   = tem_pkg::CMD_CHAR;
        it.slot = tem_pkg::INDEX_W'($urandom);
        it.code = tem_pkg::END_CODE;
        it.adv  = tem_pkg::ADV_W'($urandom);
        send_item(it, 1'b0, '0);
    endtask

    // -----------------------------------------------------------------------
    // Result side: random stall, check each transaction against the oldest
    // expectation
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                observed_extent = {line_width, max_width, text_height, is_final};
                if (pending_extents.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("[%0t] unexpected result: lw=%h mw=%h th=%h fin=%b",
                                 $realtime, line_width, max_width, text_height, is_final);
                end
                else
                begin
                    due_extent = pending_extents.pop_front();
                    if (observed_extent.lw !== due_extent.lw
                        || observed_extent.mw !== due_extent.mw
                        || observed_extent.th !== due_extent.th
                        || observed_extent.fin !== due_extent.fin)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"[%0t] mismatch: exp lw=%h mw=%h th=%h fin=%b,",
                                      " got lw=%h mw=%h th=%h fin=%b"},
                                     $realtime, due_extent.lw, due_extent.mw,
                                     due_extent.th, due_extent.fin, observed_extent.lw,
                                     observed_extent.mw, observed_extent.th,
                                     observed_extent.fin);
                    end
                end
            end
            result_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any cycle with no accepted transaction on any channel counts
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            stuck_cycles = 0;
        else
            stuck_cycles = stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        glyph_item_t fill_item;

        // Directed rows run on reset settings: one glyph, entry 0 as the
        // missing glyph, zero font height and spacing. Entry 0 is written
        // before any character needs it.
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::END_CODE,
                                          16'h0000, 1'b1, 24'd0, 24'd0, 24'd0, 1'b1));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'hFF, tem_pkg::NEWLINE_CODE,
                                          16'hFFFF, 1'b1, 24'd0, 24'd0, 24'd0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::END_CODE,
                                          16'h0000, 1'b1, 24'd0, 24'd0, 24'd0, 1'b1));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_LOAD, 8'd0, 16'h0041, 16'hFFFF,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_LOAD, 8'hFF, 16'hFFFF, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_LOAD, 8'd1, tem_pkg::NEWLINE_CODE,
                                          16'h1234, 1'b0, '0, '0, '0, 1'b0));
        // found, then two absent codes falling back to entry 0
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, 16'h0041, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, 16'hFFFF, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, 16'h0040, 16'hFFFF,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::NEWLINE_CODE,
                                          16'h0000, 1'b1, 24'd196605, 24'd196605, 24'd0,
                                          1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, 16'h0041, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::END_CODE,
                                          16'h0000, 1'b1, 24'd65535, 24'd196605, 24'd0,
                                          1'b1));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::END_CODE,
                                          16'h0000, 1'b1, 24'd0, 24'd0, 24'd0, 1'b1));
        // zero advance in the missing glyph
        directed_rows.push_back(glyph_row(tem_pkg::CMD_LOAD, 8'd0, 16'h0000, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, 16'h0041, 16'h0000,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'h5A, 16'h8000, 16'h5555,
                                          1'b0, '0, '0, '0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::NEWLINE_CODE,
                                          16'h0000, 1'b1, 24'd0, 24'd0, 24'd0, 1'b0));
        directed_rows.push_back(glyph_row(tem_pkg::CMD_CHAR, 8'd0, tem_pkg::END_CODE,
                                          16'h0000, 1'b1, 24'd0, 24'd0, 24'd0, 1'b1));

        // Hold reset, then release on a clock edge
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles lightly, receiver stalls heavily
        send_idle_pct = 16;
        recv_idle_pct = 60;
        foreach (directed_rows[k])
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);

        // Write every entry once, in ascending code order with gaps, so no
        // search ever touches an unwritten entry
        for (int slot = 0; slot < GLYPH_SLOTS; slot++)
        begin
            fill_item.op   = tem_pkg::CMD_LOAD;
            fill_item.slot = tem_pkg::INDEX_W'(slot);
            fill_item.code = tem_pkg::CODE_W'(slot * 256 + $urandom_range(255));
            fill_item.adv  = tem_pkg::ADV_W'($urandom);
            send_item(fill_item, 1'b0, '0);
        end

        // Full table, then no glyph found, then a count above the depth
        run_phase(16'd256, 16'($urandom_range(255)), 16'($urandom), 16'($urandom), 12, 1'b0);
        run_phase(16'd0, 16'd0, 16'hFFFF, 16'd0, 6, 1'b0);
        run_phase(16'd511, 16'd255, 16'd0, 16'hFFFF, 6, 1'b0);

        // Swap the pressure: sender idles heavily, receiver lightly
        send_idle_pct = 60;
        recv_idle_pct = 16;
        run_phase(16'd1, 16'($urandom_range(255)), 16'($urandom), 16'($urandom), 6, 1'b0);
        run_phase(16'($urandom_range(255, 2)), 16'($urandom_range(255)),
                  16'($urandom_range(2000)), 16'($urandom_range(2000)), 8, 1'b0);

        // No idling on either side; clip every sum
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(16'd0, 16'($urandom_range(255)), 16'hFFFF, 16'hFFFF, 0, 1'b1);
        run_phase(16'd256, 16'($urandom_range(255)), 16'($urandom), 16'($urandom), 8, 1'b0);

        wait_block_idle();
        if (mismatch_count == 0 && pending_extents.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
